/* hdl/ctsmr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctsmr_pkg
// Shared constants and types for the critical time step minimum reduce unit.
// ----------------------------------------------------------------------------
package ctsmr_pkg;

	localparam int unsigned NumAxes = 3;
	localparam logic [31:0] Scale0p3Q32 = 32'd1288490189;
	localparam logic [15:0] GroupSelectReset = 16'd1;
	localparam logic [31:0] MaxDtReset = 32'd1288490;

	// Configuration register indexes.
	localparam logic [0:0] RegGroupSelect = 1'b0;
	localparam logic [0:0] RegMaxDt = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PICK,
		ST_SQRT,
		ST_SCALE,
		ST_FOLD,
		ST_OUT
	} ctsmr_state_t;

	// Start strobe toward the divider lanes.
	typedef struct packed {
		logic start;
	} div_ctrl_t;

endpackage : ctsmr_pkg
`default_nettype wire

/* hdl/ctsmr_div_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctsmr_div_lane
// Restoring divider for one axis: floor(num * 2^64 / den), one bit a cycle,
// saturating to all ones when num >= den.
// ----------------------------------------------------------------------------
module ctsmr_div_lane
	import ctsmr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_ctrl_t   ctrl,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic [63:0]      quot,
	output logic             busy
);

	logic [31:0] rem_q;
	logic [63:0] quot_q;
	logic [6:0]  cnt_q;
	logic [31:0] den_q;
	logic        sat_q;
	logic [32:0] rem_sh;

	assign rem_sh = {rem_q, 1'b0};

	// Iterate one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q  <= num;
			quot_q <= '0;
			den_q  <= den;
			sat_q  <= (num >= den);
		end else if (cnt_q != '0) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q  <= 32'(rem_sh - {1'b0, den_q});
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[31:0];
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = sat_q ? '1 : quot_q;

endmodule : ctsmr_div_lane
`default_nettype wire

/* hdl/ctsmr_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctsmr_sqrt
// Floor square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module ctsmr_sqrt
	import ctsmr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic [31:0]      root,
	output logic             busy
);

	logic [63:0] val_q;
	logic [31:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [33:0] rem_sh;
	logic [33:0] trial;

	assign rem_sh = {rem_q, val_q[63:62]};
	assign trial  = {root_q, 2'b01};

	// Count the 32 result digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// The remainder stays below 2^32 until the last digit, whose remainder is unused.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			val_q <= {val_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= 32'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[31:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;

endmodule : ctsmr_sqrt
`default_nettype wire

/* hdl/critical_time_step_min_reduce_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// critical_time_step_min_reduce_unit
// Usage: one body record per input word (valid/stall). A counting body gets
// its critical step 0.3*sqrt(min(mass/k)) folded into a running minimum.
// The word marked last_body produces one output word (valid/stall) holding
// min(running minimum, max_dt) and a flag telling if any body counted.
// Configuration (cfg_valid/cfg_ready, index, data): 0 group_select, 1 max_dt.
// Flow: an item is worked on alone; the input is stalled outside the idle
// state. A counting body with a nonzero stiffness passes through the states
// divide (the three divider lanes in parallel: start, 64 quotient bits,
// done), pick to merge the lanes, square root, scale, fold and output, then
// back to idle. Other bodies go from idle straight to the output state.
// Bodies with no stiffness are not folded into the minimum. The output word
// is registered in the output state of the last word.
// Reset sets the running minimum to all ones and the state, flags and config to defaults.
// When the receiver stalls, the result is held in the output register and
// the next input word still enters and is computed; it waits only if a
// second result would be due.
// ----------------------------------------------------------------------------
module critical_time_step_min_reduce_unit
	import ctsmr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] body_mass,
	input  wire logic [31:0] stiffness_x,
	input  wire logic [31:0] stiffness_y,
	input  wire logic [31:0] stiffness_z,
	input  wire logic        is_dynamic,
	input  wire logic [15:0] body_groups,
	input  wire logic        record_valid,
	input  wire logic        last_body,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      time_step,
	output logic             from_bodies,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	ctsmr_state_t state_q, state_d;
	logic [15:0] group_select_q;
	logic [31:0] max_dt_q;
	logic [31:0] running_min_q;
	logic        found_any_q;
	logic        last_q;
	logic [31:0] mass_q;
	logic [31:0] k_q [NumAxes];
	logic [63:0] quot [NumAxes];
	logic [NumAxes-1:0] div_busy;
	logic [63:0] best_q;
	logic        finite_q;
	logic [31:0] root;
	logic        sqrt_busy;
	logic [63:0] prod_s1;
	logic [31:0] dt_q;
	logic        accept;
	logic        counts;
	div_ctrl_t   div_ctrl;
	logic        sqrt_start;
	logic        last_q_started;
	logic        sqrt_started;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign counts    = is_dynamic && record_valid && ((body_groups & group_select_q) != '0);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_select_q <= GroupSelectReset;
			max_dt_q       <= MaxDtReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegGroupSelect: group_select_q <= cfg_data[15:0];
				RegMaxDt:       max_dt_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Divider lanes, one per axis.
	for (genvar a = 0; a < NumAxes; a++) begin : g_lane
		ctsmr_div_lane u_div (
			.clk(clk), .arst_n(arst_n), .ctrl(div_ctrl),
			.num(mass_q), .den(k_q[a]), .quot(quot[a]), .busy(div_busy[a])
		);
	end

	ctsmr_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(best_q), .root(root), .busy(sqrt_busy)
	);

	// Next state.
	always_comb begin
		state_d    = state_q;
		div_ctrl   = '0;
		sqrt_start = 1'b0;
		case (state_q)
			ST_IDLE: if (accept) begin
				state_d = (counts && (stiffness_x != '0 || stiffness_y != '0 ||
					stiffness_z != '0)) ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				div_ctrl.start = (div_busy == '0) && !last_q_started;
				if (last_q_started && div_busy == '0) state_d = ST_PICK;
			end
			ST_PICK: begin
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				sqrt_start = !sqrt_started;
				if (sqrt_started && !sqrt_busy) state_d = ST_SCALE;
			end
			ST_SCALE: state_d = ST_FOLD;
			ST_FOLD:  state_d = ST_OUT;
			ST_OUT:   if (!last_q || !out_valid || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_q_started <= 1'b0;
			sqrt_started   <= 1'b0;
		end else begin
			state_q        <= state_d;
			last_q_started <= (state_q == ST_DIV) ? 1'b1 : 1'b0;
			sqrt_started   <= (state_q == ST_SQRT) ? 1'b1 : 1'b0;
		end
	end

	// Capture the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			mass_q <= body_mass;
			k_q[0] <= stiffness_x;
			k_q[1] <= stiffness_y;
			k_q[2] <= stiffness_z;
		end
	end

	// Merge the lanes: smallest ratio among nonzero axes.
	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			logic [63:0] b;
			logic        f;
			b = '1;
			f = 1'b0;
			for (int a = 0; a < NumAxes; a++) begin
				if (k_q[a] != '0 && (!f || quot[a] < b)) begin
					b = quot[a];
					f = 1'b1;
				end
			end
			best_q   <= b;
			finite_q <= f;
		end
		if (state_q == ST_SCALE) prod_s1 <= {32'd0, root} * {32'd0, Scale0p3Q32};
	end

	assign dt_q = prod_s1[63:32];

	// Running minimum and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= '1;
			found_any_q   <= 1'b0;
			last_q        <= 1'b0;
			out_valid     <= 1'b0;
			time_step     <= '0;
			from_bodies   <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (accept) begin
				last_q <= last_body;
				if (counts) found_any_q <= 1'b1;
			end
			if (state_q == ST_FOLD && finite_q && dt_q < running_min_q)
				running_min_q <= dt_q;
			if (state_q == ST_OUT && last_q && (!out_valid || !out_stall)) begin
				out_valid     <= 1'b1;
				from_bodies   <= found_any_q;
				time_step     <= (found_any_q && running_min_q < max_dt_q) ?
					running_min_q : max_dt_q;
				running_min_q <= '1;
				found_any_q   <= 1'b0;
			end
		end
	end

	// A result is only produced from the output state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("result without output state");
	// Input is held off while the square root runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> in_stall)
		else $error("input taken during root");
	// The found flag is cleared after a result is issued, unless a word was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |=> (found_any_q == 1'b0 || $past(accept)))
		else $error("state not cleared after result");

endmodule : critical_time_step_min_reduce_unit
`default_nettype wire
